/* hw/rtl/bitonic_block_sorter_macros.svh */
// ----------------------------------------------------------------------------
// bitonic block sorter assertion macros
// shared concurrent assertion forms, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef BITONIC_BLOCK_SORTER_MACROS_SVH
`define BITONIC_BLOCK_SORTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitonic block sorter check failed");

// next-cycle implication
`define BBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitonic block sorter check failed");

`else

`define BBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/bbs_pkg.sv */
// ----------------------------------------------------------------------------
// bbs_pkg
// types and fixed constants shared by the bitonic block sorter modules
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

    // element width
    localparam int VALUE_W = 32;

    // width of log2 size and stage counters
    localparam int LK_W = 3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 1'b1;

    // reset values of the configuration registers
    localparam logic              RST_DESCENDING = 1'b0;
    localparam logic [LK_W-1:0]   RST_SIZE_LOG2  = 3'd6;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_XCHG,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic rd_en;
        logic xchg;
        logic up;
        logic pend_wr;
        logic emit_rd;
        logic emit_last;
    } t_dp_ctl;

endpackage

`default_nettype wire

/* hw/rtl/bbs_datapath.sv */
// ----------------------------------------------------------------------------
// bbs_datapath
// element store, pair read, compare-exchange with deferred second write,
// and the registered result port
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_datapath
    import bbs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int ADDR_W       = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_ctl                   i_ctl,
    input  wire logic [ADDR_W-1:0]         i_addr_lo,
    input  wire logic [ADDR_W-1:0]         i_addr_hi,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic signed [VALUE_W-1:0]      o_sorted_value,
    output logic                           o_last,
    output logic                           o_valid
);

    logic [VALUE_W-1:0] mem [MAX_ELEMENTS];

    logic [VALUE_W-1:0] r_rd_a;
    logic [VALUE_W-1:0] r_rd_b;
    logic [VALUE_W-1:0] r_byp;
    logic               r_fwd_a;
    logic               r_fwd_b;
    logic [ADDR_W-1:0]  r_addr_lo;
    logic [ADDR_W-1:0]  r_addr_hi;
    logic [VALUE_W-1:0] r_pend_data;
    logic [ADDR_W-1:0]  r_pend_addr;
    logic               r_pend_vld;
    logic               n_pend_vld;
    logic               r_out_valid;
    logic               r_out_last;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [VALUE_W-1:0] val_a;
    logic [VALUE_W-1:0] val_b;
    logic               a_gt_b;
    logic               swap;
    logic [VALUE_W-1:0] lo_val;
    logic [VALUE_W-1:0] hi_val;

    // operands with bypass of a write that hit the read address
    assign val_a  = r_fwd_a ? r_byp : r_rd_a;
    assign val_b  = r_fwd_b ? r_byp : r_rd_b;
    assign a_gt_b = $signed(val_a) > $signed(val_b);
    assign swap   = (i_ctl.up == a_gt_b);
    assign lo_val = swap ? val_b : val_a;
    assign hi_val = swap ? val_a : val_b;

    // single write port: load, exchange low half, or pending high half
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = i_addr_lo;
        wr_data    = i_value;
        n_pend_vld = r_pend_vld;
        if (i_ctl.load_we) begin
            wr_en   = 1'b1;
        end else if (i_ctl.xchg) begin
            wr_en      = 1'b1;
            wr_addr    = r_addr_lo;
            wr_data    = lo_val;
            n_pend_vld = 1'b1;
        end else if (i_ctl.pend_wr) begin
            wr_en      = r_pend_vld;
            wr_addr    = r_pend_addr;
            wr_data    = r_pend_data;
            n_pend_vld = 1'b0;
        end
    end

    // store write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered pair read with bypass capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en || i_ctl.emit_rd) begin
            r_rd_a    <= mem[i_addr_lo];
            r_rd_b    <= mem[i_addr_hi];
            r_addr_lo <= i_addr_lo;
            r_addr_hi <= i_addr_hi;
            r_fwd_a   <= wr_en && (wr_addr == i_addr_lo);
            r_fwd_b   <= wr_en && (wr_addr == i_addr_hi);
            r_byp     <= wr_data;
        end
    end

    // high half of an exchange waits for the next free write slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.xchg) begin
            r_pend_data <= hi_val;
            r_pend_addr <= r_addr_hi;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= i_ctl.emit_rd;
            r_out_last  <= i_ctl.emit_rd && i_ctl.emit_last;
        end
    end

    assign o_sorted_value = r_rd_a;
    assign o_last         = r_out_last;
    assign o_valid        = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/bbs_ctrl.sv */
// ----------------------------------------------------------------------------
// bbs_ctrl
// configuration registers, load counter and the sequencer that walks the
// bitonic network stage by stage, pair by pair, then reads out the block
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitonic_block_sorter_macros.svh"

module bbs_ctrl
    import bbs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int ADDR_W       = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_start,
    output logic                       o_busy,
    output t_dp_ctl                    o_ctl,
    output logic [ADDR_W-1:0]          o_addr_lo,
    output logic [ADDR_W-1:0]          o_addr_hi
);

    localparam int CNT_W   = ADDR_W + 1;
    localparam int MAX_LOG = $clog2(MAX_ELEMENTS + 1) - 1;

    t_state            r_state;
    t_state            n_state;
    logic              r_desc;
    logic [LK_W-1:0]   r_size;
    logic [ADDR_W-1:0] r_load_count;
    logic [ADDR_W-1:0] n_load_count;
    logic [LK_W-1:0]   r_slog;
    logic [LK_W-1:0]   n_slog;
    logic              r_up;
    logic              n_up;
    logic [LK_W-1:0]   r_lk;
    logic [LK_W-1:0]   n_lk;
    logic [LK_W-1:0]   r_lj;
    logic [LK_W-1:0]   n_lj;
    logic [ADDR_W-1:0] r_q;
    logic [ADDR_W-1:0] n_q;
    logic [ADDR_W-1:0] r_eidx;
    logic [ADDR_W-1:0] n_eidx;

    logic              accept;
    logic [LK_W-1:0]   slog_eff;
    logic [CNT_W-1:0]  load_n;
    logic [CNT_W-1:0]  blk_n;
    logic              load_done;
    logic              q_last;
    logic              eidx_last;
    logic [LK_W:0]     lj_p1;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] pair_lo;
    logic [ADDR_W-1:0] pair_hi;
    logic [CNT_W-1:0]  pair_hi_ext;
    logic              dir_bit;
    logic              up_cur;

    // block size clamped to the supported range
    always_comb begin
        if (r_size < LK_W'(1)) begin
            slog_eff = LK_W'(1);
        end else if (r_size > LK_W'(MAX_LOG)) begin
            slog_eff = LK_W'(MAX_LOG);
        end else begin
            slog_eff = r_size;
        end
    end

    assign accept    = i_start && (r_state == ST_IDLE);
    assign load_n    = CNT_W'(1) << slog_eff;
    assign blk_n     = CNT_W'(1) << r_slog;
    assign load_done = ({1'b0, r_load_count} + CNT_W'(1)) >= load_n;
    assign q_last    = ({1'b0, r_q} + CNT_W'(1)) == (blk_n >> 1);
    assign eidx_last = ({1'b0, r_eidx} + CNT_W'(1)) == blk_n;

    // pair addresses: insert a zero at bit lj of the pair index
    assign lj_p1       = {1'b0, r_lj} + (LK_W + 1)'(1);
    assign low_mask    = ~({ADDR_W{1'b1}} << r_lj);
    assign pair_lo     = ((r_q >> r_lj) << lj_p1) | (r_q & low_mask);
    assign pair_hi     = pair_lo | (ADDR_W'(1) << r_lj);
    assign pair_hi_ext = {1'b0, pair_hi};

    // direction: final merge uses the configured order, inner runs alternate
    assign dir_bit = |((pair_lo >> r_lk) & ADDR_W'(1));
    assign up_cur  = (r_lk == r_slog) ? r_up : ~dir_bit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= RST_DESCENDING;
            r_size <= RST_SIZE_LOG2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DESCENDING: r_desc <= i_cfg_data[0];
                CFG_SIZE_LOG2:  r_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state and counters
    always_comb begin
        n_state      = r_state;
        n_load_count = r_load_count;
        n_slog       = r_slog;
        n_up         = r_up;
        n_lk         = r_lk;
        n_lj         = r_lj;
        n_q          = r_q;
        n_eidx       = r_eidx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (load_done) begin
                        n_load_count = '0;
                        n_slog       = slog_eff;
                        n_up         = ~r_desc;
                        n_lk         = LK_W'(1);
                        n_lj         = '0;
                        n_q          = '0;
                        n_state      = ST_READ;
                    end else begin
                        n_load_count = r_load_count + ADDR_W'(1);
                    end
                end
            end
            ST_READ: begin
                n_state = ST_XCHG;
            end
            ST_XCHG: begin
                n_state = ST_READ;
                if (!q_last) begin
                    n_q = r_q + ADDR_W'(1);
                end else begin
                    n_q = '0;
                    if (r_lj != '0) begin
                        n_lj = r_lj - LK_W'(1);
                    end else if (r_lk != r_slog) begin
                        n_lk = r_lk + LK_W'(1);
                        n_lj = r_lk;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                n_eidx  = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (eidx_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_eidx = r_eidx + ADDR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_ctl     = '0;
        o_addr_lo = r_load_count;
        o_addr_hi = pair_hi;
        case (r_state)
            ST_IDLE: begin
                o_ctl.load_we = accept;
            end
            ST_READ: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.pend_wr = 1'b1;
                o_addr_lo     = pair_lo;
            end
            ST_XCHG: begin
                o_ctl.xchg = 1'b1;
                o_ctl.up   = up_cur;
                o_addr_lo  = pair_lo;
            end
            ST_FLUSH: begin
                o_ctl.pend_wr = 1'b1;
            end
            ST_EMIT: begin
                o_ctl.emit_rd   = 1'b1;
                o_ctl.emit_last = eidx_last;
                o_addr_lo       = r_eidx;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_load_count <= '0;
            r_slog       <= LK_W'(1);
            r_up         <= 1'b1;
            r_lk         <= LK_W'(1);
            r_lj         <= '0;
            r_q          <= '0;
            r_eidx       <= '0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_slog       <= n_slog;
            r_up         <= n_up;
            r_lk         <= n_lk;
            r_lj         <= n_lj;
            r_q          <= n_q;
            r_eidx       <= n_eidx;
        end
    end

    // every pair read is followed by its exchange
    `BBS_ASSERT_NXT(a_read_then_xchg, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_XCHG)
    // pair addresses stay inside the block and are distinct
    `BBS_ASSERT_IMP(a_pair_in_block, i_clk, i_rst_n, r_state == ST_READ, (pair_hi_ext < blk_n) && (pair_lo != pair_hi))
    // readout of the final element returns the block to loading
    `BBS_ASSERT_NXT(a_emit_ends, i_clk, i_rst_n, (r_state == ST_EMIT) && eidx_last, (r_state == ST_IDLE) && (r_load_count == '0))
    // a completed block starts the network at its first stage
    `BBS_ASSERT_NXT(a_sort_start, i_clk, i_rst_n, accept && load_done, (r_lk == LK_W'(1)) && (r_lj == '0) && (r_q == '0))

endmodule

`default_nettype wire

/* hw/rtl/bitonic_block_sorter.sv */
// ----------------------------------------------------------------------------
// bitonic block sorter
// loads a block of 2^size_log2 signed values, sorts it with a bitonic
// network over a single element store and streams the sorted block out
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start, busy          | i_value
//  result   | o_valid              | o_sorted_value, o_last
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  loading takes one value per cycle while busy is low; the value that
//  completes a block of n starts the network: (n/2)*log2(n)*(log2(n)+1)/2
//  pairs, each read and then exchanged on the one store write port, a flush
//  state to drain the last exchange, then n results, one per cycle, each
//  shown in the cycle after readout reads its element
//  busy is high after the completing transfer until the last readout cycle;
//  the result port has no stall and every result is taken when it is shown
//  reset clears control state and restores the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module bitonic_block_sorter
    import bbs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_valid,
    output logic signed [VALUE_W-1:0]      o_sorted_value,
    output logic                           o_last
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);

    t_dp_ctl           dp_ctl;
    logic [ADDR_W-1:0] addr_lo;
    logic [ADDR_W-1:0] addr_hi;

    // sequencer
    bbs_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (start),
        .o_busy     (busy),
        .o_ctl      (dp_ctl),
        .o_addr_lo  (addr_lo),
        .o_addr_hi  (addr_hi)
    );

    // store and compare-exchange
    bbs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (dp_ctl),
        .i_addr_lo      (addr_lo),
        .i_addr_hi      (addr_hi),
        .i_value        (i_value),
        .o_sorted_value (o_sorted_value),
        .o_last         (o_last),
        .o_valid        (o_valid)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// bitonic block sorter testbench
// loads blocks of signed values under many size and direction settings,
// predicts each sorted block locally and checks every streamed result
// ----------------------------------------------------------------------------
module tb;
    import bbs_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam int MAX_LOG2     = 6;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_sorted_out;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      start;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_sorted_value;
    logic                      o_last;

    // local copy of the sorter state and registers
    logic signed [VALUE_W-1:0] block_store [MAX_ELEMENTS];
    int                        load_cnt;
    logic                      sort_desc;
    logic [CFG_DATA_W-1:0]     size_log2;

    // sorted values still to come out of the block
    t_sorted_out sorted_queue [$];

    int idle_pct;
    int errors;
    int items_sent;
    int results_seen;
    int blocks_done;

    bitonic_block_sorter #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_sorted_value(o_sorted_value),
        .o_last        (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sorted_queue.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // effective block length, out-of-range sizes clamped
    function automatic int block_len();
        int s;
        s = int'(size_log2);
        if (s < 1) s = 1;
        if (s > MAX_LOG2) s = MAX_LOG2;
        return 1 << s;
    endfunction

    // store one accepted value; a completed block is sorted and queued
    function automatic void load_value(logic signed [VALUE_W-1:0] v);
        int                        n;
        int                        j;
        logic signed [VALUE_W-1:0] key;
        t_sorted_out               r;
        n = block_len();
        if (load_cnt < MAX_ELEMENTS) block_store[load_cnt] = v;
        load_cnt = (load_cnt + 1) & 'h7f;
        if (load_cnt < n) return;
        // insertion sort over the first n entries, extra entries dropped
        for (int i = 1; i < n; i++) begin
            key = block_store[i];
            j = i - 1;
            while (j >= 0 && (sort_desc ? block_store[j] < key : block_store[j] > key)) begin
                block_store[j + 1] = block_store[j];
                j--;
            end
            block_store[j + 1] = key;
        end
        for (int i = 0; i < n; i++) begin
            r.value = block_store[i];
            r.last  = (i == n - 1);
            sorted_queue.push_back(r);
        end
        load_cnt = 0;
        blocks_done++;
    endfunction

    // mixes full-range, clustered and extreme values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return $urandom;
        if (roll < 80) return $signed($urandom_range(16)) - 8;
        case ($urandom_range(3))
            0: return 32'sh8000_0000 + $urandom_range(3);
            1: return 32'sh7fff_ffff - $urandom_range(3);
            2: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endtask

    // compare each result transfer with the oldest queued value
    always @(posedge i_clk) begin
        t_sorted_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (sorted_queue.size() == 0) begin
                note_mismatch($sformatf("unexpected result value %0d last %0b",
                                        o_sorted_value, o_last));
            end else begin
                want = sorted_queue.pop_front();
                if (o_sorted_value !== want.value || o_last !== want.last)
                    note_mismatch($sformatf("expected value %0d last %0b, got %0d last %0b",
                                            want.value, want.last, o_sorted_value, o_last));
            end
        end
    end

    // drop start and let the sorter drain and settle
    task automatic wait_quiet();
        @(negedge i_clk);
        start = 1'b0;
        while (sorted_queue.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // one value transfer, each cycle ahead of it idle with the set odds
    task automatic send_value(logic signed [VALUE_W-1:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start   = 1'b0;
            i_value = $urandom;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_value = v;
        do @(posedge i_clk); while (busy);
        load_value(v);
        items_sent++;
    endtask

    // register write on an idle sorter
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = CFG_DATA_W'($urandom);
        if (idx == CFG_DESCENDING) sort_desc = data[0];
        else size_log2 = data;
    endtask

    // direction write carries random upper bits
    task automatic set_mode(logic desc, logic [CFG_DATA_W-1:0] size);
        write_cfg(CFG_DESCENDING, {2'($urandom), desc});
        write_cfg(CFG_SIZE_LOG2, size);
    endtask

    // keep sending until the current block completes
    task automatic finish_block();
        do send_value(pick_value()); while (load_cnt != 0);
    endtask

    // full block of 64 ascending straight out of reset
    task automatic test_reset_defaults();
        finish_block();
    endtask

    // field extremes and duplicates in both directions
    task automatic test_value_extremes();
        set_mode(1'b0, 3'd1);
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        set_mode(1'b1, 3'd1);
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        set_mode(1'b1, 3'd2);
        send_value(0);
        send_value(-1);
        send_value(32'sh7fff_ffff);
        send_value(-1);
        set_mode(1'b0, 3'd2);
        send_value(32'sh8000_0000);
        send_value(0);
        send_value(32'sh8000_0000);
        send_value(1);
    endtask

    // size below range acts as a pair
    task automatic test_size_clamp_low();
        set_mode(1'b1, 3'd0);
        send_value(-5);
        send_value(7);
    endtask

    // size above range acts as 64
    task automatic test_size_clamp_high();
        set_mode(1'($urandom_range(1)), 3'd7);
        finish_block();
    endtask

    // registers changed while a block is partly loaded
    task automatic test_midblock_change();
        set_mode(1'b0, 3'd7);
        send_value(40);
        send_value(-3);
        send_value(32'sh7fff_ffff);
        send_value(9);
        send_value(-100);
        // shrink below the load count: next value closes a block of 4
        set_mode(1'b1, 3'd2);
        send_value(55);
        // grow after one value
        set_mode(1'b0, 3'd1);
        send_value(12);
        write_cfg(CFG_SIZE_LOG2, 3'd2);
        send_value(-12);
        send_value(0);
        send_value(12);
    endtask

    // random blocks, mostly small, some cut by a register change
    task automatic test_random_blocks(int target);
        int stop_at;
        int roll;
        int cut;
        logic [CFG_DATA_W-1:0] size;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 8) size = 3'd0;
            else if (roll < 14) size = 3'd5;
            else if (roll < 17) size = CFG_DATA_W'($urandom_range(6, 7));
            else size = CFG_DATA_W'($urandom_range(1, 4));
            set_mode(1'($urandom_range(1)), size);
            cut = ($urandom_range(99) < 15) ? int'($urandom_range(1, block_len() - 1)) : 0;
            do begin
                send_value(pick_value());
                if (cut != 0 && load_cnt == cut) begin
                    set_mode(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(0, 4)));
                    cut = 0;
                end
            end while (load_cnt != 0);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_DESCENDING;
        i_cfg_data = '0;
        start      = 1'b0;
        i_value    = '0;
        load_cnt   = 0;
        sort_desc  = RST_DESCENDING;
        size_log2  = RST_SIZE_LOG2;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        blocks_done  = 0;
        idle_pct     = 21;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_value_extremes();
        test_size_clamp_low();
        test_midblock_change();
        test_random_blocks(8);

        idle_pct = 58;
        test_size_clamp_high();
        test_random_blocks(8);

        idle_pct = 0;
        test_random_blocks(8);

        wait_quiet();
        repeat (100) @(negedge i_clk);
        if (sorted_queue.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", sorted_queue.size()));

        $display("%0d values loaded into %0d blocks, %0d sorted results checked",
                 items_sent, blocks_done, results_seen);
        $display("sizes 2 to 64 with out-of-range sizes, both directions, mid-block changes");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_datapath.sv
hw/rtl/bbs_ctrl.sv
hw/rtl/bitonic_block_sorter.sv
tb/tb.sv
